>>> hdl/epd_pkg.sv
`timescale 1ns / 1ps

package epd_pkg;

  // Saturation limit of the near and far streak counters.
  localparam int STREAK_MAX = 255;
  localparam int STREAK_W   = $clog2(STREAK_MAX + 1);
  // Compare width that holds both a streak count and an 8-bit sample limit.
  localparam int CNT_W      = (STREAK_W > 8) ? STREAK_W : 8;

  // Item kinds.
  localparam logic [1:0] MODE_EDGE    = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_CONSUME = 2'd2;

  // Configuration register map (word index, byte address is 4 times this).
  localparam int          ADDR_W        = 5;
  localparam logic [2:0]  REG_MIN_ECHO  = 3'd0;
  localparam logic [2:0]  REG_MAX_ECHO  = 3'd1;
  localparam logic [2:0]  REG_HAND      = 3'd2;
  localparam logic [2:0]  REG_STALE     = 3'd3;
  localparam logic [2:0]  REG_SET       = 3'd4;
  localparam logic [2:0]  REG_CLEAR     = 3'd5;

  localparam logic [15:0] RST_MIN_ECHO  = 16'd100;
  localparam logic [15:0] RST_MAX_ECHO  = 16'd25000;
  localparam logic [15:0] RST_HAND      = 16'd1480;
  localparam logic [31:0] RST_STALE     = 32'd250000;
  localparam logic [7:0]  RST_SET       = 8'd2;
  localparam logic [7:0]  RST_CLEAR     = 8'd2;

  typedef struct packed {
    logic [15:0] min_echo_us;
    logic [15:0] max_echo_us;
    logic [15:0] hand_width_us;
    logic [31:0] stale_timeout_us;
    logic [7:0]  set_samples;
    logic [7:0]  clear_samples;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_us;
    logic        echo_level;
  } item_t;

  typedef struct packed {
    logic        hand_near;
    logic        collect_event;
    logic        event_waiting;
    logic [15:0] last_echo_us;
  } res_t;

  typedef struct packed {
    logic [STREAK_W-1:0] near_cnt;
    logic [STREAK_W-1:0] far_cnt;
    logic                present;
    logic                latch;
  } streak_t;

  // One in-range or out-of-range result applied to the streak state.
  function automatic streak_t streak_step(streak_t s, logic is_near,
                                          logic [7:0] set_n, logic [7:0] clr_n);
    streak_t r;
    r = s;
    if (is_near) begin
      r.far_cnt = '0;
      if (s.near_cnt != STREAK_W'(STREAK_MAX)) begin
        r.near_cnt = s.near_cnt + STREAK_W'(1);
      end
      if (!s.present && (CNT_W'(r.near_cnt) >= CNT_W'(set_n))) begin
        r.present = 1'b1;
        r.latch   = 1'b1;
      end
    end else begin
      r.near_cnt = '0;
      if (s.far_cnt != STREAK_W'(STREAK_MAX)) begin
        r.far_cnt = s.far_cnt + STREAK_W'(1);
      end
      if (s.present && (CNT_W'(r.far_cnt) >= CNT_W'(clr_n))) begin
        r.present = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/epd_regs.sv
`timescale 1ns / 1ps

module epd_regs import epd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_echo_us      <= RST_MIN_ECHO;
      cfg_q.max_echo_us      <= RST_MAX_ECHO;
      cfg_q.hand_width_us    <= RST_HAND;
      cfg_q.stale_timeout_us <= RST_STALE;
      cfg_q.set_samples      <= RST_SET;
      cfg_q.clear_samples    <= RST_CLEAR;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_ECHO: cfg_q.min_echo_us      <= pwdata[15:0];
        REG_MAX_ECHO: cfg_q.max_echo_us      <= pwdata[15:0];
        REG_HAND:     cfg_q.hand_width_us    <= pwdata[15:0];
        REG_STALE:    cfg_q.stale_timeout_us <= pwdata;
        REG_SET:      cfg_q.set_samples      <= pwdata[7:0];
        REG_CLEAR:    cfg_q.clear_samples    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_ECHO: prdata = {16'd0, cfg_q.min_echo_us};
      REG_MAX_ECHO: prdata = {16'd0, cfg_q.max_echo_us};
      REG_HAND:     prdata = {16'd0, cfg_q.hand_width_us};
      REG_STALE:    prdata = cfg_q.stale_timeout_us;
      REG_SET:      prdata = {24'd0, cfg_q.set_samples};
      REG_CLEAR:    prdata = {24'd0, cfg_q.clear_samples};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

>>> hdl/epd_core.sv
`timescale 1ns / 1ps

module epd_core import epd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic        echo_active_q, echo_active_d;
  logic [31:0] rise_time_q, rise_time_d;
  logic        pulse_pending_q, pulse_pending_d;
  logic [31:0] pending_width_q, pending_width_d;
  logic [31:0] measure_time_q, measure_time_d;
  streak_t     streak_q, streak_d;
  logic [15:0] valid_width_q, valid_width_d;

  logic        in_win, is_near, stuck, stale, consumed;
  logic [31:0] meas_t, rise_age, meas_age;
  streak_t     s1, s2, s3;

  // Tick evaluation: pending width, then stuck echo, then stale measurement.
  always_comb begin
    in_win   = (pending_width_q >= {16'd0, cfg_i.min_echo_us}) &&
               (pending_width_q <= {16'd0, cfg_i.max_echo_us});
    is_near  = in_win && (pending_width_q <= {16'd0, cfg_i.hand_width_us});
    meas_t   = pulse_pending_q ? item_i.now_us : measure_time_q;
    s1       = pulse_pending_q ?
               streak_step(streak_q, is_near, cfg_i.set_samples, cfg_i.clear_samples) :
               streak_q;
    rise_age = item_i.now_us - rise_time_q;
    stuck    = echo_active_q && (rise_age > {16'd0, cfg_i.max_echo_us});
    s2       = stuck ? streak_step(s1, 1'b0, cfg_i.set_samples, cfg_i.clear_samples) : s1;
    meas_age = item_i.now_us - meas_t;
    stale    = (meas_t != 32'd0) && (meas_age > cfg_i.stale_timeout_us);
    s3       = stale ? streak_step(s2, 1'b0, cfg_i.set_samples, cfg_i.clear_samples) : s2;
  end

  always_comb begin
    echo_active_d   = echo_active_q;
    rise_time_d     = rise_time_q;
    pulse_pending_d = pulse_pending_q;
    pending_width_d = pending_width_q;
    measure_time_d  = measure_time_q;
    streak_d        = streak_q;
    valid_width_d   = valid_width_q;
    consumed        = 1'b0;
    unique case (item_i.mode)
      MODE_EDGE: begin
        if (item_i.echo_level) begin
          rise_time_d   = item_i.now_us;
          echo_active_d = 1'b1;
        end else if (echo_active_q) begin
          pending_width_d = rise_age;
          pulse_pending_d = 1'b1;
          echo_active_d   = 1'b0;
        end
      end
      MODE_TICK: begin
        pulse_pending_d = 1'b0;
        measure_time_d  = meas_t;
        if (pulse_pending_q && in_win) begin
          valid_width_d = pending_width_q[15:0];
        end
        if (stuck) begin
          echo_active_d = 1'b0;
        end
        streak_d = s3;
      end
      MODE_CONSUME: begin
        if (streak_q.latch) begin
          streak_d.latch = 1'b0;
          consumed       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res_o.hand_near     = streak_d.present;
  assign res_o.collect_event = consumed;
  assign res_o.event_waiting = streak_d.latch;
  assign res_o.last_echo_us  = valid_width_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_active_q   <= 1'b0;
      rise_time_q     <= '0;
      pulse_pending_q <= 1'b0;
      pending_width_q <= '0;
      measure_time_q  <= '0;
      streak_q        <= '0;
      valid_width_q   <= '0;
    end else if (fire_i) begin
      echo_active_q   <= echo_active_d;
      rise_time_q     <= rise_time_d;
      pulse_pending_q <= pulse_pending_d;
      pending_width_q <= pending_width_d;
      measure_time_q  <= measure_time_d;
      streak_q        <= streak_d;
      valid_width_q   <= valid_width_d;
    end
  end

endmodule

>>> hdl/echo_pulse_presence_detector.sv
`timescale 1ns / 1ps
// A result passes through the input register and then the result register, written by the
// single evaluation pass, before it can transfer out on the result channel.
// Throughput: one item per cycle while results are taken; every item gives exactly one result.
// Reset: rst_ni is asynchronous and active low; it empties both registers, clears all
// detector state to zero and loads the configuration registers with their defaults.

module echo_pulse_presence_detector import epd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input item channel.
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [31:0]       now_us_i,
  input  logic              echo_level_i,
  // Result channel.
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hand_near_o,
  output logic              collect_event_o,
  output logic              event_waiting_o,
  output logic [15:0]       last_echo_us_o,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_valid_q;
  res_t  res_d, res_q;
  logic  out_valid_q;
  logic  out_go;
  logic  fire;

  // The result register can take a new value when it is empty or being drained.
  // The input register advances whenever the result register can take its result; while a
  // result waits untaken, an empty input register still accepts one item and then holds it.
  assign out_go     = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_go;
  assign in_ready_o = !in_valid_q || out_go;

  epd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register: holds one accepted item until its result is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{mode: mode_i, now_us: now_us_i, echo_level: echo_level_i};
    end
  end

  // The core evaluates the held item against the detector state and commits the
  // new state on the same edge that the result register loads.
  epd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hand_near_o     = res_q.hand_near;
  assign collect_event_o = res_q.collect_event;
  assign event_waiting_o = res_q.event_waiting;
  assign last_echo_us_o  = res_q.last_echo_us;

`ifndef SYNTHESIS
  // Consuming the collect event always leaves the latch clear.
  a_consume_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && collect_event_o |-> !event_waiting_o)
    else $error("collect event consumed but latch still set");

  // The input side only stalls when a result is waiting and not taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

  // A held item that cannot advance stays in the input register.
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_go |=> in_valid_q && $stable(item_q))
    else $error("held item lost while the result side stalled");
`endif

endmodule
